FILE: hdl/ulaplus_attribute_framebuffer_unit_assert.svh
// Assertion macros for the ULAplus attribute framebuffer unit.
`ifndef ULAPLUS_ATTRIBUTE_FRAMEBUFFER_UNIT_ASSERT_SVH
`define ULAPLUS_ATTRIBUTE_FRAMEBUFFER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ULAFB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ulafb assertion failed");
`define ULAFB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ulafb assertion failed");
`else
`define ULAFB_ASSERT(label, prop)
`define ULAFB_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: hdl/ulafb_pkg.sv
// Types, codes and helpers shared by the ULAplus attribute framebuffer.
package ulafb_pkg;

    localparam int WIDTH_PIXELS_DEF  = 256;
    localparam int HEIGHT_PIXELS_DEF = 192;

    typedef enum logic [2:0] {
        OP_PLOT       = 3'd0,
        OP_PICK       = 3'd1,
        OP_LOAD_PIXEL = 3'd2,
        OP_LOAD_ATTR  = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    localparam logic [1:0] SEL_INK     = 2'd0;
    localparam logic [1:0] SEL_PAPER   = 2'd1;
    localparam logic [1:0] SEL_PALETTE = 2'd2;

    localparam logic [2:0] INK_RESET     = 3'd0;
    localparam logic [2:0] PAPER_RESET   = 3'd7;
    localparam logic [1:0] PALETTE_RESET = 2'd0;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    function automatic logic [2:0] attr_ink(input logic [7:0] a);
        return a[2:0];
    endfunction

    function automatic logic [2:0] attr_paper(input logic [7:0] a);
        return a[5:3];
    endfunction

    function automatic logic [1:0] attr_palette(input logic [7:0] a);
        return a[7:6];
    endfunction

    function automatic logic [7:0] pack_attr(input logic [2:0] ink, input logic [2:0] paper,
                                             input logic [1:0] palette);
        return {palette, paper, ink};
    endfunction

endpackage

FILE: hdl/ulaplus_attribute_framebuffer_unit.sv
// ULAplus attribute framebuffer: pixel and attribute stores with plot, pick, load and read.
// Requests arrive on the s_axis channel; op travels in tuser, the other fields in tdata.
// Only a read-cell-row request produces a response on the m_axis channel; all other
// requests, and requests with off-screen coordinates or out-of-range load addresses,
// produce none. Each request is handled in two steps: the cycle it is accepted issues the
// reads of both stores, and in S_EXEC the registered read data is used to write back,
// update the current colors or load the response register. No new request is accepted
// until the unit is back in S_IDLE after the second step of the previous one.
// After reset both stores are swept to zero, one address per cycle, covering all
// (WIDTH_PIXELS + 7) / 8 * HEIGHT_PIXELS addresses (6144 at the default size); no request
// is accepted until the sweep is done. The attribute height register may be written
// through cfg_we at any time the unit is idle.
// The response sits in an output register. When the receiver stalls, the unit still
// accepts the next request, but a further read request waits in S_EXEC until
// the pending response has been taken.
`include "ulaplus_attribute_framebuffer_unit_assert.svh"
module ulaplus_attribute_framebuffer_unit
    import ulafb_pkg::*;
#(
    parameter int WIDTH_PIXELS  = WIDTH_PIXELS_DEF,
    parameter int HEIGHT_PIXELS = HEIGHT_PIXELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x[7:0], y[15:8], set_bit[16], color_select[18:17], byte_address[31:19],
    // data_byte[39:32]
    input  logic [39:0] s_axis_tdata,
    // op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ink_mask[7:0], ink_color[13:8], paper_color[19:14], zero[23:20]
    output logic [23:0] m_axis_tdata
);

    localparam int Stride     = (WIDTH_PIXELS + 7) / 8;
    localparam int StoreBytes = Stride * HEIGHT_PIXELS;
    localparam int AddrW      = $clog2(StoreBytes);

    logic [7:0]  in_x;
    logic [7:0]  in_y;
    logic        in_set_bit;
    logic [1:0]  in_color_select;
    logic [12:0] in_byte_address;
    logic [7:0]  in_data_byte;
    logic [2:0]  in_op;

    assign in_x            = s_axis_tdata[7:0];
    assign in_y            = s_axis_tdata[15:8];
    assign in_set_bit      = s_axis_tdata[16];
    assign in_color_select = s_axis_tdata[18:17];
    assign in_byte_address = s_axis_tdata[31:19];
    assign in_data_byte    = s_axis_tdata[39:32];
    assign in_op           = s_axis_tuser;

    state_t           state_reg, state_next;
    logic [AddrW-1:0] clr_addr_reg, clr_addr_next;
    logic             attr_height_mode_reg;
    logic [2:0]       cur_ink_reg, cur_ink_next;
    logic [2:0]       cur_paper_reg, cur_paper_next;
    logic [1:0]       cur_palette_reg, cur_palette_next;

    logic [2:0]       op_reg;
    logic             do_reg;
    logic [AddrW-1:0] pix_addr_reg;
    logic [AddrW-1:0] attr_addr_reg;
    logic [2:0]       x_lo_reg;
    logic             set_bit_reg;
    logic [1:0]       color_select_reg;
    logic [7:0]       data_byte_reg;

    logic [7:0]       pix_rdata_reg;
    logic [7:0]       attr_rdata_reg;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_mask_reg;
    logic [5:0]       out_ink_reg;
    logic [5:0]       out_paper_reg;
    logic             out_load;

    logic             accept;
    logic             on_screen;
    logic             load_ok;
    logic             do_next;
    logic [31:0]      pix_calc;
    logic [31:0]      attr_calc;
    logic [7:0]       attr_row;
    logic [AddrW-1:0] pix_addr_next;
    logic [AddrW-1:0] attr_addr_next;
    logic [AddrW-1:0] load_addr;

    logic             pix_we;
    logic [AddrW-1:0] pix_waddr;
    logic [7:0]       pix_wdata;
    logic             attr_we;
    logic [AddrW-1:0] attr_waddr;
    logic [7:0]       attr_wdata;
    logic [7:0]       pix_bit;

    logic [7:0]       pix_mem  [StoreBytes];
    logic [7:0]       attr_mem [StoreBytes];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign on_screen = (32'(in_x) < WIDTH_PIXELS) && (32'(in_y) < HEIGHT_PIXELS);
    assign load_ok   = 32'(in_byte_address) < StoreBytes;
    assign load_addr = AddrW'(32'(in_byte_address));
    assign attr_row  = attr_height_mode_reg ? (in_y >> 3) : in_y;
    assign pix_calc  = 32'(in_y) * Stride + 32'(in_x[7:3]);
    assign attr_calc = 32'(attr_row) * Stride + 32'(in_x[7:3]);

    always_comb
    begin
        pix_addr_next  = AddrW'(pix_calc);
        attr_addr_next = AddrW'(attr_calc);
        do_next        = 1'b0;
        case (in_op)
            OP_PLOT, OP_PICK, OP_READ:
            begin
                do_next = on_screen;
            end
            OP_LOAD_PIXEL, OP_LOAD_ATTR:
            begin
                do_next        = load_ok;
                pix_addr_next  = load_addr;
                attr_addr_next = load_addr;
            end
            default:
            begin
                do_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_height_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            attr_height_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            do_reg <= 1'b0;
        end
        else if (accept)
        begin
            do_reg <= do_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg           <= in_op;
            pix_addr_reg     <= pix_addr_next;
            attr_addr_reg    <= attr_addr_next;
            x_lo_reg         <= in_x[2:0];
            set_bit_reg      <= in_set_bit;
            color_select_reg <= in_color_select;
            data_byte_reg    <= in_data_byte;
        end
    end

    assign pix_bit = 8'h80 >> x_lo_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        cur_ink_next     = cur_ink_reg;
        cur_paper_next   = cur_paper_reg;
        cur_palette_next = cur_palette_reg;
        out_load         = 1'b0;
        pix_we           = 1'b0;
        pix_waddr        = pix_addr_reg;
        pix_wdata        = data_byte_reg;
        attr_we          = 1'b0;
        attr_waddr       = attr_addr_reg;
        attr_wdata       = data_byte_reg;
        case (state_reg)
            S_CLEAR:
            begin
                pix_we     = 1'b1;
                pix_waddr  = clr_addr_reg;
                pix_wdata  = 8'h00;
                attr_we    = 1'b1;
                attr_waddr = clr_addr_reg;
                attr_wdata = 8'h00;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (32'(clr_addr_reg) == StoreBytes - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (do_reg)
                begin
                    case (op_reg)
                        OP_PLOT:
                        begin
                            pix_we     = 1'b1;
                            pix_wdata  = (pix_rdata_reg & ~pix_bit) |
                                         (set_bit_reg ? pix_bit : 8'h00);
                            attr_we    = 1'b1;
                            attr_wdata = pack_attr(cur_ink_reg, cur_paper_reg,
                                                   cur_palette_reg);
                        end
                        OP_PICK:
                        begin
                            case (color_select_reg)
                                SEL_INK:     cur_ink_next     = attr_ink(attr_rdata_reg);
                                SEL_PAPER:   cur_paper_next   = attr_paper(attr_rdata_reg);
                                SEL_PALETTE: cur_palette_next = attr_palette(attr_rdata_reg);
                                default:     cur_ink_next     = cur_ink_reg;
                            endcase
                        end
                        OP_LOAD_PIXEL:
                        begin
                            pix_we = 1'b1;
                        end
                        OP_LOAD_ATTR:
                        begin
                            attr_we = 1'b1;
                        end
                        OP_READ:
                        begin
                            if (out_valid_reg && !m_axis_tready)
                            begin
                                state_next = S_EXEC;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            cur_ink_reg     <= INK_RESET;
            cur_paper_reg   <= PAPER_RESET;
            cur_palette_reg <= PALETTE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            cur_ink_reg     <= cur_ink_next;
            cur_paper_reg   <= cur_paper_next;
            cur_palette_reg <= cur_palette_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mask_reg  <= pix_rdata_reg;
            out_ink_reg   <= {attr_palette(attr_rdata_reg), 1'b0, attr_ink(attr_rdata_reg)};
            out_paper_reg <= {attr_palette(attr_rdata_reg), 1'b1, attr_paper(attr_rdata_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (accept)
        begin
            pix_rdata_reg <= pix_mem[pix_addr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[attr_waddr] <= attr_wdata;
        end
        if (accept)
        begin
            attr_rdata_reg <= attr_mem[attr_addr_next];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_paper_reg, out_ink_reg, out_mask_reg};

    `ULAFB_ASSERT(a_no_response_in_clear, (state_reg == S_CLEAR) |-> !out_valid_reg)
    `ULAFB_ASSERT(a_accept_to_exec, accept |=> (state_reg == S_EXEC))
    `ULAFB_ASSERT(a_response_from_read,
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC && op_reg == OP_READ && do_reg))
    `ULAFB_ASSERT(a_no_write_when_idle, (state_reg == S_IDLE) |-> (!pix_we && !attr_we))

endmodule

FILE: bench/ulaplus_attribute_framebuffer_unit_tb.sv
// Self-checking testbench for the ULAplus attribute framebuffer unit with a mirrored store model.
module ulaplus_attribute_framebuffer_unit_tb;
    import ulafb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRIDE = (WIDTH_PIXELS_DEF + 7) / 8;
    localparam int STORE_BYTES = STRIDE * HEIGHT_PIXELS_DEF;
    localparam int ADDR_TOP = (1 << 13) - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [1:0] SEL_NONE = 2'd3;
    localparam logic [2:0] OP_FIRST_UNUSED = 3'(OP_READ) + 3'd1;
    localparam logic [2:0] OP_LAST_UNUSED = 3'b111;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        set_bit;
        logic [1:0]  color_select;
        logic [12:0] byte_address;
        logic [7:0]  data_byte;
    } fb_request_t;

    localparam int REQUEST_BITS = $bits(fb_request_t);

    typedef struct packed {
        logic [7:0] ink_mask;
        logic [5:0] ink_color;
        logic [5:0] paper_color;
    } cell_row_t;

    class cell_row_scoreboard;
        logic [7:0] pixels [STORE_BYTES];
        logic [7:0] attrs [STORE_BYTES];
        logic [2:0] ink;
        logic [2:0] paper;
        logic [1:0] palette;
        bit         eight_line;
        cell_row_t  rows_due [$];
        int         mismatches;

        function new();
            foreach (pixels[i])
            begin
                pixels[i] = 8'h00;
                attrs[i] = 8'h00;
            end
            ink = INK_RESET;
            paper = PAPER_RESET;
            palette = PALETTE_RESET;
            eight_line = 1'b1;
            mismatches = 0;
        endfunction

        function int attr_index(logic [7:0] x, logic [7:0] y);
            return (int'(y) / (eight_line ? 8 : 1)) * STRIDE + int'(x) / 8;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void note_request(fb_request_t r);
            bit         on_screen;
            int         pix;
            int         attr_at;
            logic [7:0] bit_mask;
            logic [7:0] a;
            cell_row_t  row;
            on_screen = int'(r.x) < WIDTH_PIXELS_DEF && int'(r.y) < HEIGHT_PIXELS_DEF;
            pix = int'(r.y) * STRIDE + int'(r.x) / 8;
            attr_at = attr_index(r.x, r.y);
            a = on_screen ? attrs[attr_at] : 8'h00;
            case (r.op)
                OP_PLOT:
                    if (on_screen)
                    begin
                        bit_mask = 8'h80 >> r.x[2:0];
                        pixels[pix] = r.set_bit ? (pixels[pix] | bit_mask)
                                                : (pixels[pix] & ~bit_mask);
                        attrs[attr_at] = {palette, paper, ink};
                    end
                OP_PICK:
                    if (on_screen)
                    begin
                        case (r.color_select)
                            SEL_INK:     ink = a[2:0];
                            SEL_PAPER:   paper = a[5:3];
                            SEL_PALETTE: palette = a[7:6];
                            default:     ;
                        endcase
                    end
                OP_LOAD_PIXEL:
                    if (int'(r.byte_address) < STORE_BYTES)
                        pixels[r.byte_address] = r.data_byte;
                OP_LOAD_ATTR:
                    if (int'(r.byte_address) < STORE_BYTES)
                        attrs[r.byte_address] = r.data_byte;
                OP_READ:
                    if (on_screen)
                    begin
                        row.ink_mask = pixels[pix];
                        row.ink_color = 6'(int'(a[7:6]) * 16 + int'(a[2:0]));
                        row.paper_color = 6'(int'(a[7:6]) * 16 + 8 + int'(a[5:3]));
                        rows_due = {rows_due, row};
                    end
                default: ;
            endcase
        endfunction

        function void check_response(logic [23:0] d);
            cell_row_t want;
            if (rows_due.size() == 0)
            begin
                $error("unexpected cell row response: %h", d);
                mismatches++;
                return;
            end
            want = rows_due.pop_front();
            if (d[7:0] !== want.ink_mask)
            begin
                $error("ink_mask: expected %h, got %h", want.ink_mask, d[7:0]);
                mismatches++;
            end
            if (d[13:8] !== want.ink_color)
            begin
                $error("ink_color: expected %0d, got %0d", want.ink_color, d[13:8]);
                mismatches++;
            end
            if (d[19:14] !== want.paper_color)
            begin
                $error("paper_color: expected %0d, got %0d", want.paper_color, d[19:14]);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // x[7:0], y[15:8], set_bit[16], color_select[18:17], byte_address[31:19],
    // data_byte[39:32]
    logic [39:0] s_axis_tdata;
    // op[2:0]
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // ink_mask[7:0], ink_color[13:8], paper_color[19:14], zero[23:20]
    logic [23:0] m_axis_tdata;

    cell_row_scoreboard rows = new();
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    bit   long_hold = 1'b0;
    int   quiet_cycles = 0;
    event long_hold_go;

    ulaplus_attribute_framebuffer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= !long_hold && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always
    begin
        @(long_hold_go);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            rows.check_response(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic fb_request_t make_request(logic [2:0] op, int x, int y, bit set_bit,
                                                 logic [1:0] sel, int addr, int data);
        fb_request_t r;
        r.op = op;
        r.x = 8'(x);
        r.y = 8'(y);
        r.set_bit = set_bit;
        r.color_select = sel;
        r.byte_address = 13'(addr);
        r.data_byte = 8'(data);
        return r;
    endfunction

    function automatic logic [7:0] hot_x();
        if ($urandom_range(0, 9) < 3)
            return 8'($urandom);
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
    endfunction

    function automatic logic [7:0] hot_y();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'($urandom_range(HEIGHT_PIXELS_DEF, 255));
        if (roll < 3)
            return 8'($urandom_range(0, HEIGHT_PIXELS_DEF - 1));
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(176, 191));
    endfunction

    function automatic fb_request_t random_request();
        fb_request_t r;
        int          roll;
        r = fb_request_t'(REQUEST_BITS'({$urandom, $urandom}));
        r.x = hot_x();
        r.y = hot_y();
        roll = $urandom_range(0, 99);
        if (roll < 30)
            r.op = OP_PLOT;
        else if (roll < 45)
            r.op = OP_PICK;
        else if (roll < 55)
            r.op = OP_LOAD_PIXEL;
        else if (roll < 65)
            r.op = OP_LOAD_ATTR;
        else if (roll < 95)
            r.op = OP_READ;
        else
            r.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            if (r.op == OP_LOAD_ATTR)
                r.byte_address = 13'(rows.attr_index(r.x, 8'(int'(r.y) % HEIGHT_PIXELS_DEF)));
            else
                r.byte_address = 13'((int'(r.y) % HEIGHT_PIXELS_DEF) * STRIDE + int'(r.x) / 8);
        end
        else if (roll < 85)
            r.byte_address = 13'($urandom_range(0, STORE_BYTES - 1));
        else
            r.byte_address = 13'($urandom_range(STORE_BYTES, ADDR_TOP));
        return r;
    endfunction

    task automatic send_request(input fb_request_t r);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {r.data_byte, r.byte_address, r.color_select, r.set_bit, r.y, r.x};
        do @(posedge clk); while (!s_axis_tready);
        rows.note_request(r);
        @(negedge clk);
    endtask

    task automatic set_cell_height(input bit eight_line);
        while (rows.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= eight_line;
        @(negedge clk);
        cfg_we <= 1'b0;
        rows.eight_line = eight_line;
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                              input int hold_at);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                -> long_hold_go;
            send_request(random_request());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_PLOT;
        m_axis_tready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(make_request(OP_READ, 0, 0, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_PLOT, 255, 191, 1, SEL_INK, 0, 0));
        send_request(make_request(OP_READ, 255, 191, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_PLOT, 0, 0, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_LOAD_ATTR, 0, 0, 0, SEL_INK, 0, 8'hFF));
        send_request(make_request(OP_READ, 0, 0, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_PICK, 3, 2, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_PICK, 3, 2, 0, SEL_PAPER, 0, 0));
        send_request(make_request(OP_PICK, 3, 2, 0, SEL_PALETTE, 0, 0));
        send_request(make_request(OP_PICK, 3, 2, 1, SEL_NONE, 0, 0));
        send_request(make_request(OP_PLOT, 7, 0, 1, SEL_INK, 0, 0));
        send_request(make_request(OP_READ, 0, 0, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_LOAD_PIXEL, 0, 0, 0, SEL_INK, STORE_BYTES - 1, 8'hA5));
        send_request(make_request(OP_READ, 255, 191, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_LOAD_PIXEL, 0, 0, 0, SEL_INK, STORE_BYTES, 8'hFF));
        send_request(make_request(OP_LOAD_ATTR, 0, 0, 0, SEL_INK, ADDR_TOP, 8'hFF));
        send_request(make_request(OP_READ, 255, 191, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_READ, 0, 192, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_PLOT, 255, 255, 1, SEL_INK, 0, 0));
        send_request(make_request(OP_PICK, 0, 200, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_FIRST_UNUSED, 0, 0, 1, SEL_INK, 0, 8'h55));
        send_request(make_request(OP_LAST_UNUSED, 255, 255, 1, SEL_NONE, ADDR_TOP, 8'hFF));
        send_request(make_request(OP_READ, 128, 100, 0, SEL_INK, 0, 0));
        send_request(make_request(OP_PICK, 255, 191, 0, SEL_PALETTE, 0, 0));
        send_request(make_request(OP_READ, 0, 0, 0, SEL_INK, 0, 0));
        s_axis_tvalid <= 1'b0;

        set_cell_height(1'b0);
        run_random(260, 0, 0, 60);
        set_cell_height(1'b1);
        run_random(260, 85, 0, -1);
        set_cell_height(1'b0);
        run_random(260, 0, 85, -1);
        set_cell_height(1'b1);
        run_random(260, 6, 6, -1);
        set_cell_height(1'b0);
        run_random(260, 0, 0, -1);

        while (rows.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (rows.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: ulaplus_attribute_framebuffer_unit.f
+incdir+hdl
hdl/ulafb_pkg.sv
hdl/ulaplus_attribute_framebuffer_unit.sv
bench/ulaplus_attribute_framebuffer_unit_tb.sv
